// File: design/clnw_pkg.sv
// Shared types, codes and constants of the character-LCD number writer.
package clnw_pkg;

  localparam int MAX_DIGITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH        = 2;
  localparam int MAG_W              = 16;
  localparam int BCD_DIGITS         = 5;
  localparam int BCD_W              = 4 * BCD_DIGITS;

  localparam logic [2:0] OP_CHAR = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_SDEC = 3'd2;
  localparam logic [2:0] OP_HEX  = 3'd3;
  localparam logic [2:0] OP_BIN  = 3'd4;

  localparam logic [1:0] LINE_TOP = 2'd1;

  localparam logic [7:0] CMD_BASE       = 8'h80;
  localparam logic [7:0] LINE2_OFFSET   = 8'h40;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_HEX_ALPHA = 8'h41;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  line;
    logic [4:0]  column;
    logic [15:0] value;
    logic [4:0]  length;
  } clnw_req_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] bus_byte;
    logic       last;
  } clnw_wr_t;

  // One classified request as handed from the front end to the write sequencer.
  typedef struct packed {
    logic [7:0]       cmd;
    logic [2:0]       op;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [BCD_W-1:0] bcd;
    logic [4:0]       count;
  } clnw_job_t;

endpackage

// File: design/char_lcd_number_writer.sv
// Top level of the character-LCD number writer: front end, request queue and write sequencer.
//
// Each request beat (a character, an unsigned or signed decimal, a hex or a binary number,
// with line, column, value and digit count) becomes a run of LCD bus-write beats: first the
// set-address command for the line and column, then a sign character for signed decimal,
// then the digits from most to least significant in ASCII, with last set on the final beat.
// Digit places above the width of the number print as zero, and a digit count above
// MAX_DIGITS is held to MAX_DIGITS. The front end takes one request at a time; a decimal
// then passes through a bit-serial binary-to-BCD converter, one magnitude bit per step,
// before it is handed to the queue, and the front end takes no new request until the
// current one has been handed on. The write sequencer loads a request and then writes
// one beat per cycle while the LCD side takes each beat, and loads no new request until
// it has issued the final beat of the current one. The two halves overlap through a
// two-entry queue, so the sustained cost of a request is set by the slower half.
module char_lcd_number_writer #(
  parameter int MAX_DIGITS = clnw_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  // Request channel: one display request per beat.
  input  logic                req_valid,
  output logic                req_ready,
  input  clnw_pkg::clnw_req_t req,
  // LCD write channel: one bus write per beat.
  output logic                lcd_valid,
  input  logic                lcd_ready,
  output clnw_pkg::clnw_wr_t  lcd
);

  // Front end to queue.
  logic                fq_valid;
  logic                fq_ready;
  clnw_pkg::clnw_job_t fq_job;

  // Queue to write sequencer.
  logic                qb_valid;
  logic                qb_ready;
  clnw_pkg::clnw_job_t qb_job;

  // The front end computes the cursor command, the sign and magnitude, the clipped
  // digit count, and for decimal requests the BCD digits of the magnitude.
  clnw_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  // The queue lets the front end start converting the next request while the
  // sequencer is still writing out the previous one, or is held by the LCD side.
  clnw_queue #(
    .DEPTH (clnw_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  // The sequencer writes the beats through its own output register, so a stalled
  // LCD side holds the sequencer first; the front end keeps working until the queue
  // behind the sequencer is full.
  clnw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .lcd_valid (lcd_valid),
    .lcd_ready (lcd_ready),
    .lcd       (lcd)
  );

endmodule

// File: design/clnw_front.sv
// Front end: accepts requests, builds the cursor command and converts decimals to BCD.
module clnw_front #(
  parameter int MAX_DIGITS = clnw_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  clnw_pkg::clnw_req_t req,
  output logic                job_valid,
  input  logic                job_ready,
  output clnw_pkg::clnw_job_t job
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam int STEP_W = $clog2(clnw_pkg::MAG_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(clnw_pkg::MAG_W - 1);
  localparam logic [4:0] LEN_MAX = 5'(MAX_DIGITS);

  logic [1:0]                    state;
  logic [STEP_W-1:0]             step;
  logic [clnw_pkg::MAG_W-1:0]    bin;
  logic [7:0]                    addr;
  logic [7:0]                    cmd_in;
  logic                          neg_in;
  logic [clnw_pkg::MAG_W-1:0]    mag_in;
  logic [4:0]                    count_in;
  logic                          numeric;
  logic                          decimal;
  logic [clnw_pkg::BCD_W-1:0]    bcd_adj;
  logic [clnw_pkg::BCD_W-1:0]    bcd_next;

  assign req_ready = (state == ST_IDLE);
  assign job_valid = (state == ST_PUSH);

  always_comb begin
    addr     = {3'b000, req.column} - 8'd1;
    cmd_in   = (req.line == clnw_pkg::LINE_TOP) ? (clnw_pkg::CMD_BASE | addr)
                                                : (clnw_pkg::CMD_BASE |
                                                   (addr + clnw_pkg::LINE2_OFFSET));
    neg_in   = (req.operation == clnw_pkg::OP_SDEC) && req.value[15];
    mag_in   = neg_in ? (~req.value + 16'd1) : req.value;
    numeric  = (req.operation == clnw_pkg::OP_UDEC) || (req.operation == clnw_pkg::OP_SDEC) ||
               (req.operation == clnw_pkg::OP_HEX)  || (req.operation == clnw_pkg::OP_BIN);
    decimal  = (req.operation == clnw_pkg::OP_UDEC) || (req.operation == clnw_pkg::OP_SDEC);
    count_in = !numeric ? 5'd0 : ((req.length > LEN_MAX) ? LEN_MAX : req.length);
  end

  // One double-dabble step: add three to every digit of five or more, then shift.
  always_comb begin
    for (int d = 0; d < clnw_pkg::BCD_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (job.bcd[4*d +: 4] >= 4'd5) ? (job.bcd[4*d +: 4] + 4'd3)
                                                       : job.bcd[4*d +: 4];
    end
    bcd_next = {bcd_adj[clnw_pkg::BCD_W-2:0], bin[clnw_pkg::MAG_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            step  <= '0;
            state <= decimal ? ST_CONV : ST_PUSH;
          end
        end
        ST_CONV: begin
          step <= step + 1'b1;
          if (step == STEP_LAST) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (job_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      job.cmd   <= cmd_in;
      job.op    <= req.operation;
      job.neg   <= neg_in;
      job.mag   <= mag_in;
      job.bcd   <= '0;
      job.count <= count_in;
      bin       <= mag_in;
    end else if (state == ST_CONV) begin
      job.bcd <= bcd_next;
      bin     <= {bin[clnw_pkg::MAG_W-2:0], 1'b0};
    end
  end

  // Only decimal requests spend time in the converter.
  a_conv_decimal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (job.op == clnw_pkg::OP_UDEC || job.op == clnw_pkg::OP_SDEC))
    else $error("converter running on a non-decimal request");

  // A conversion always runs its full number of steps before hand-off.
  a_conv_full: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_CONV && state == ST_PUSH) |-> ($past(step) == STEP_LAST))
    else $error("conversion left early");

endmodule

// File: design/clnw_queue.sv
// Short FIFO of classified requests between the front end and the write sequencer.
module clnw_queue #(
  parameter int DEPTH = clnw_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  clnw_pkg::clnw_job_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output clnw_pkg::clnw_job_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

  clnw_pkg::clnw_job_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != COUNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Occupancy never exceeds the storage.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("queue occupancy overflow");

endmodule

// File: design/clnw_back.sv
// Write sequencer: turns one classified request into its run of LCD bus writes.
module clnw_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  clnw_pkg::clnw_job_t job,
  output logic                lcd_valid,
  input  logic                lcd_ready,
  output clnw_pkg::clnw_wr_t  lcd
);

  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_CHAR  = 2'd1;
  localparam logic [1:0] PH_SIGN  = 2'd2;
  localparam logic [1:0] PH_DIGIT = 2'd3;

  clnw_pkg::clnw_job_t cur;
  clnw_pkg::clnw_wr_t  beat;
  logic                busy;
  logic [1:0]          phase;
  logic [1:0]          phase_next;
  logic [4:0]          remaining;
  logic [4:0]          remaining_next;
  logic                advance;
  logic [3:0]          place;
  logic [3:0]          nib;
  logic [7:0]          digit_char;
  logic                numeric;

  assign job_ready = !busy;
  assign advance   = busy && (!lcd_valid || lcd_ready);

  always_comb begin
    place = 4'(remaining - 5'd1);
    nib   = 4'd0;
    case (cur.op)
      clnw_pkg::OP_HEX: begin
        nib = (place < 4'd4) ? cur.mag[{place[1:0], 2'b00} +: 4] : 4'd0;
      end
      clnw_pkg::OP_BIN: begin
        nib = {3'b000, cur.mag[place]};
      end
      default: begin
        case (place)
          4'd0:    nib = cur.bcd[3:0];
          4'd1:    nib = cur.bcd[7:4];
          4'd2:    nib = cur.bcd[11:8];
          4'd3:    nib = cur.bcd[15:12];
          4'd4:    nib = cur.bcd[19:16];
          default: nib = 4'd0;
        endcase
      end
    endcase
    digit_char = (nib < 4'd10) ? (clnw_pkg::CHAR_ZERO + {4'b0000, nib})
                               : (clnw_pkg::CHAR_HEX_ALPHA + {4'b0000, nib} - 8'd10);
  end

  always_comb begin
    numeric        = (cur.op == clnw_pkg::OP_UDEC) || (cur.op == clnw_pkg::OP_HEX) ||
                     (cur.op == clnw_pkg::OP_BIN);
    beat           = '0;
    phase_next     = phase;
    remaining_next = remaining;
    case (phase)
      PH_CMD: begin
        beat.register_select = 1'b0;
        beat.bus_byte        = cur.cmd;
        if (cur.op == clnw_pkg::OP_CHAR) begin
          beat.last  = 1'b0;
          phase_next = PH_CHAR;
        end else if (cur.op == clnw_pkg::OP_SDEC) begin
          beat.last  = 1'b0;
          phase_next = PH_SIGN;
        end else if (numeric) begin
          beat.last  = (remaining == 5'd0);
          phase_next = PH_DIGIT;
        end else begin
          beat.last  = 1'b1;
        end
      end
      PH_CHAR: begin
        beat.register_select = 1'b1;
        beat.bus_byte        = cur.mag[7:0];
        beat.last            = 1'b1;
      end
      PH_SIGN: begin
        beat.register_select = 1'b1;
        beat.bus_byte        = cur.neg ? clnw_pkg::CHAR_MINUS : clnw_pkg::CHAR_PLUS;
        beat.last            = (remaining == 5'd0);
        phase_next           = PH_DIGIT;
      end
      PH_DIGIT: begin
        beat.register_select = 1'b1;
        beat.bus_byte        = digit_char;
        beat.last            = (remaining == 5'd1);
        remaining_next       = remaining - 5'd1;
      end
      default: begin
        beat.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      lcd_valid <= 1'b0;
      phase     <= PH_CMD;
      remaining <= '0;
    end else begin
      if (!busy && job_valid) begin
        busy      <= 1'b1;
        phase     <= PH_CMD;
        remaining <= job.count;
      end
      if (advance) begin
        lcd_valid <= 1'b1;
        phase     <= phase_next;
        remaining <= remaining_next;
        if (beat.last) begin
          busy <= 1'b0;
        end
      end else if (lcd_valid && lcd_ready) begin
        lcd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && job_valid) begin
      cur <= job;
    end
    if (advance) begin
      lcd <= beat;
    end
  end

  // The digit phase is only reached with digits still to write.
  a_digit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (busy && phase == PH_DIGIT) |-> (remaining != 5'd0))
    else $error("digit phase with nothing left to write");

  // Writing the final beat of a request frees the sequencer.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (advance && beat.last) |=> (!busy && lcd_valid && lcd.last))
    else $error("request did not end on its final beat");

endmodule

// File: dv/char_lcd_number_writer_test.sv
// Self-checking testbench for the character-LCD number writer.
`timescale 1ns / 1ps

module char_lcd_number_writer_test;

  // Operation codes that the block does not define; they must give only the cursor command.
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // Line codes. Only the top-line code selects the top line; every other code means the
  // second line.
  localparam logic [1:0] LINE_SECOND = 2'd2;
  localparam logic [1:0] LINE_ZERO   = 2'd0;
  localparam logic [1:0] LINE_THREE  = 2'd3;

  localparam int PHASE_ITEMS  = 34;
  localparam int SETTLE_TICKS = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REQ_W        = $bits(clnw_pkg::clnw_req_t);

  // One row of the directed table. A nonzero typed_count means the expected bus bytes are
  // typed in (first byte in the top slot); otherwise the row is checked by the predictor.
  typedef struct packed {
    clnw_pkg::clnw_req_t request;
    logic [1:0]          typed_count;
    logic [23:0]         typed_bytes;
  } directed_row_t;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_ready;
  clnw_pkg::clnw_req_t req;
  logic                lcd_valid;
  logic                lcd_ready;
  clnw_pkg::clnw_wr_t  lcd;

  directed_row_t      directed_rows[$];
  // Writes for the request just accepted, as {register_select, bus_byte}.
  logic [8:0]         write_run[$];
  // Bus writes still owed by the block, oldest first.
  clnw_pkg::clnw_wr_t lcd_writes_due[$];

  int failures = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_stall_pct;

  char_lcd_number_writer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .lcd_valid (lcd_valid),
    .lcd_ready (lcd_ready),
    .lcd       (lcd)
  );

  always #6 clk = ~clk;

  function automatic void flag_failure(input string note);
    if (failures < 10) begin
      $display("%0t ns: %s", $time, note);
    end
    failures++;
  endfunction

  // Works out the bus writes for one request into write_run: the set-address command,
  // then the character, or the sign and digits of a number.
  function automatic void predict_writes(input clnw_pkg::clnw_req_t r);
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [7:0]  ch;
    int unsigned mag;
    int unsigned q;
    int unsigned d;
    int unsigned digits;
    int unsigned place;
    write_run.delete();
    // column-1 is taken in eight bits, so column zero wraps to the top of the address space.
    addr = {3'b000, r.column} - 8'd1;
    if (r.line == clnw_pkg::LINE_TOP) begin
      cmd = clnw_pkg::CMD_BASE | addr;
    end else begin
      cmd = addr + clnw_pkg::LINE2_OFFSET;
      cmd = clnw_pkg::CMD_BASE | cmd;
    end
    write_run.push_back({1'b0, cmd});
    if (r.operation == clnw_pkg::OP_CHAR) begin
      write_run.push_back({1'b1, r.value[7:0]});
    end else if (r.operation <= clnw_pkg::OP_BIN) begin
      digits = (r.length > clnw_pkg::MAX_DIGITS_DEFAULT) ? clnw_pkg::MAX_DIGITS_DEFAULT
                                                         : r.length;
      mag = r.value;
      if (r.operation == clnw_pkg::OP_SDEC) begin
        if (r.value[15]) begin
          write_run.push_back({1'b1, clnw_pkg::CHAR_MINUS});
          mag = 32'h10000 - r.value;
        end else begin
          write_run.push_back({1'b1, clnw_pkg::CHAR_PLUS});
        end
      end
      for (int p = digits; p > 0; p--) begin
        place = p - 1;
        case (r.operation)
          clnw_pkg::OP_HEX: begin
            d = (place < 4) ? ((mag >> (4 * place)) & 32'hF) : 0;
            ch = (d < 10) ? clnw_pkg::CHAR_ZERO + 8'(d)
                          : clnw_pkg::CHAR_HEX_ALPHA + 8'(d - 10);
          end
          clnw_pkg::OP_BIN: begin
            d = (place < 16) ? ((mag >> place) & 32'h1) : 0;
            ch = clnw_pkg::CHAR_ZERO + 8'(d);
          end
          default: begin
            // Places above five digits divide down to zero, which is what the block prints.
            q = mag;
            for (int k = 0; k < place; k++) q = q / 10;
            d = q % 10;
            ch = clnw_pkg::CHAR_ZERO + 8'(d);
          end
        endcase
        write_run.push_back({1'b1, ch});
      end
    end
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [1:0] ln,
                                  input logic [4:0] col, input logic [15:0] val,
                                  input logic [4:0] len, input logic [1:0] n,
                                  input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2);
    directed_row_t row;
    row.request.operation = op;
    row.request.line      = ln;
    row.request.column    = col;
    row.request.value     = val;
    row.request.length    = len;
    row.typed_count       = n;
    row.typed_bytes       = {b0, b1, b2};
    directed_rows.push_back(row);
  endfunction

  // Mostly well-formed requests with random content; the rest is noise over every field,
  // which reaches the spare operation codes, odd lines, column zero and oversized lengths.
  function automatic clnw_pkg::clnw_req_t random_request();
    clnw_pkg::clnw_req_t r;
    r = clnw_pkg::clnw_req_t'(REQ_W'($urandom));
    if ($urandom_range(99) < 80) begin
      r.operation = 3'($urandom_range(clnw_pkg::OP_BIN, clnw_pkg::OP_CHAR));
      r.line      = 2'($urandom_range(LINE_SECOND, clnw_pkg::LINE_TOP));
      r.column    = 5'($urandom_range(16, 1));
      r.length    = 5'($urandom_range(16, 1));
    end
    return r;
  endfunction

  // Offers one request beat, waiting out a random idle gap first. Valid is only lowered
  // when a gap is taken, so back-to-back beats keep it high. The expected writes are
  // queued at the edge where the beat is accepted.
  task automatic send_request(input clnw_pkg::clnw_req_t r, input logic [1:0] typed_count,
                              input logic [23:0] typed_bytes);
    clnw_pkg::clnw_wr_t w;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (typed_count != 0) begin
      write_run.delete();
      for (int i = 0; i < typed_count; i++) begin
        write_run.push_back({i != 0, typed_bytes[23 - 8 * i -: 8]});
      end
    end else begin
      predict_writes(r);
    end
    for (int i = 0; i < write_run.size(); i++) begin
      w = clnw_pkg::clnw_wr_t'({write_run[i], i == write_run.size() - 1});
      lcd_writes_due.push_back(w);
    end
  endtask

  // Holds the request channel quiet until every owed write has come out.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (lcd_writes_due.size() != 0) @(negedge clk);
  endtask

  // The write side stalls at random, with its decision made at each falling edge.
  initial begin
    lcd_ready = 1'b0;
    forever begin
      @(negedge clk);
      lcd_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted write beat is compared against the oldest expected write.
  always @(posedge clk) begin : check_beat
    clnw_pkg::clnw_wr_t due;
    if (!rst && lcd_valid && lcd_ready) begin
      if (lcd_writes_due.size() == 0) begin
        flag_failure($sformatf("unexpected write rs=%0b byte=%02h last=%0b",
                               lcd.register_select, lcd.bus_byte, lcd.last));
      end else begin
        due = lcd_writes_due.pop_front();
        if (lcd.register_select !== due.register_select || lcd.bus_byte !== due.bus_byte ||
            lcd.last !== due.last) begin
          flag_failure({$sformatf("write mismatch: expected rs=%0b byte=%02h last=%0b, ",
                                  due.register_select, due.bus_byte, due.last),
                        $sformatf("got rs=%0b byte=%02h last=%0b",
                                  lcd.register_select, lcd.bus_byte, lcd.last)});
        end
      end
    end
  end

  // A run that hangs is cut off here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Rows with typed results: characters, cursor addressing on every line code including
    // column zero and column 31, spare operation codes, zero-length numbers and one-digit
    // numbers.
    add_row(clnw_pkg::OP_CHAR, clnw_pkg::LINE_TOP, 5'd1, 16'h0041, 5'd1,
            2'd2, 8'h80, 8'h41, 8'h00);
    add_row(clnw_pkg::OP_CHAR, LINE_SECOND, 5'd16, 16'hFF7E, 5'd31,
            2'd2, 8'hCF, 8'h7E, 8'h00);
    add_row(clnw_pkg::OP_CHAR, LINE_ZERO, 5'd31, 16'h0000, 5'd0,
            2'd2, 8'hDE, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_CHAR, LINE_THREE, 5'd0, 16'h00FF, 5'd5,
            2'd2, 8'hBF, 8'hFF, 8'h00);
    add_row(clnw_pkg::OP_CHAR, clnw_pkg::LINE_TOP, 5'd0, 16'h1234, 5'd16,
            2'd2, 8'hFF, 8'h34, 8'h00);
    add_row(OP_SPARE5, clnw_pkg::LINE_TOP, 5'd1, 16'hFFFF, 5'd16,
            2'd1, 8'h80, 8'h00, 8'h00);
    add_row(OP_SPARE6, LINE_SECOND, 5'd5, 16'h5555, 5'd3,
            2'd1, 8'hC4, 8'h00, 8'h00);
    add_row(OP_SPARE7, clnw_pkg::LINE_TOP, 5'd31, 16'hFFFF, 5'd31,
            2'd1, 8'h9E, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_UDEC, clnw_pkg::LINE_TOP, 5'd3, 16'hFFFF, 5'd0,
            2'd1, 8'h82, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_SDEC, clnw_pkg::LINE_TOP, 5'd1, 16'h8000, 5'd0,
            2'd2, 8'h80, clnw_pkg::CHAR_MINUS, 8'h00);
    add_row(clnw_pkg::OP_SDEC, LINE_SECOND, 5'd1, 16'h0000, 5'd0,
            2'd2, 8'hC0, clnw_pkg::CHAR_PLUS, 8'h00);
    add_row(clnw_pkg::OP_UDEC, clnw_pkg::LINE_TOP, 5'd16, 16'h0000, 5'd1,
            2'd2, 8'h8F, clnw_pkg::CHAR_ZERO, 8'h00);
    add_row(clnw_pkg::OP_HEX, LINE_SECOND, 5'd2, 16'h000F, 5'd1,
            2'd2, 8'hC1, 8'h46, 8'h00);
    add_row(clnw_pkg::OP_BIN, clnw_pkg::LINE_TOP, 5'd1, 16'h0001, 5'd1,
            2'd2, 8'h80, 8'h31, 8'h00);
    // Rows checked by the predictor: full-width values, padding zeros above the width of
    // the number, the most negative signed value and lengths past the digit limit.
    add_row(clnw_pkg::OP_UDEC, clnw_pkg::LINE_TOP, 5'd1, 16'hFFFF, 5'd5,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_UDEC, LINE_SECOND, 5'd1, 16'hFFFF, 5'd16,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_UDEC, clnw_pkg::LINE_TOP, 5'd8, 16'd12345, 5'd31,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_SDEC, LINE_SECOND, 5'd17, 16'h8000, 5'd5,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_SDEC, clnw_pkg::LINE_TOP, 5'd2, 16'hFFFF, 5'd3,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_SDEC, clnw_pkg::LINE_TOP, 5'd1, 16'h7FFF, 5'd16,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_HEX, LINE_SECOND, 5'd1, 16'hABCD, 5'd16,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_HEX, clnw_pkg::LINE_TOP, 5'd13, 16'h1234, 5'd4,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_BIN, clnw_pkg::LINE_TOP, 5'd1, 16'hA5C3, 5'd16,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_BIN, LINE_SECOND, 5'd1, 16'hFFFF, 5'd20,
            2'd0, 8'h00, 8'h00, 8'h00);
    add_row(clnw_pkg::OP_HEX, LINE_ZERO, 5'd9, 16'hFFFF, 5'd31,
            2'd0, 8'h00, 8'h00, 8'h00);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at full speed on both sides.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].request, directed_rows[i].typed_count,
                   directed_rows[i].typed_bytes);
    end
    drain();

    // Random part in four idling phases; each phase ends with the sender holding off
    // until the block has delivered everything it owes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(), 2'd0, 24'h0);
      end
      drain();
    end

    // Give the block time to show any write beyond what was expected.
    repeat (SETTLE_TICKS) @(posedge clk);
    if (failures == 0 && lcd_writes_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
